[design/i2cm_pkg.sv]
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine: command kinds,
// sequencer phases, register indexes, engine state and result layout.
// ---------------------------------------------------------------------------
package i2cm_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int UNIT_W          = 16;
  localparam int TOUT_W          = 8;
  localparam int KIND_W          = 3;
  localparam int PHASE_W         = 4;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 16;
  localparam int CFG_ADDR_W      = 1;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST  = 16'd168;
  localparam logic [TOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNIT_TICKS  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SP_A    = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SP_B    = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WR_SET  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_LOW  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_WR_HIGH = 4'd7;
  localparam logic [PHASE_W-1:0] PH_AK_LOW  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_AK_DLY  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_AK_POLL = 4'd10;
  localparam logic [PHASE_W-1:0] PH_RD_LOW  = 4'd11;
  localparam logic [PHASE_W-1:0] PH_RD_HIGH = 4'd12;
  localparam logic [PHASE_W-1:0] PH_RA_SET  = 4'd13;
  localparam logic [PHASE_W-1:0] PH_RA_HIGH = 4'd14;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [3:0]         bit_index;
    logic [7:0]         shift_data;
    logic [TOUT_W-1:0]  ack_wait;
    logic               scl;
    logic               sda;
    logic               sda_rel;
    logic [1:0]         units_left;
    logic               ack_choice;
    logic               err_pending;
    logic [7:0]         rx_hold;
  } i2cm_state_t;

  // Packed MSB first: scl_out lands in bit 0
  typedef struct packed {
    logic       cmd_rejected;
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_released;
    logic       sda_out;
    logic       scl_out;
  } i2cm_result_t;

  localparam i2cm_state_t STATE_RST = '0;

endpackage

[design/i2c_master_byte_engine_core.sv]
// ---------------------------------------------------------------------------
// i2c_master_byte_engine_core
// I2C master line sequencer with start, stop, write byte and read byte.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the kind (tick,
//   start, stop, write byte, read byte), in_tdata the byte to send, the
//   ACK choice for reads and the sampled SDA level. Bus time advances only
//   on tick requests; one delay unit is unit_ticks ticks (zero acts as one).
//   Every request yields exactly one result on the out_ stream with the
//   SCL/SDA levels to drive, busy/done flags, the last received byte and
//   the ack error and reject flags.
//   The result is registered: out_tvalid rises in the cycle after
//   acceptance. One request is taken per cycle while out_tready is high.
//   The engine state and the result register are updated together from the
//   accepted request, so the rate is set by that single register stage.
//   The cfg_ port writes unit_ticks (index 0) and ack_timeout (index 1);
//   write them only while the engine is idle.
//   Reset (rst_n low, synchronous) returns the engine to idle with both
//   lines driven low and restores the register defaults.
//   While out_tready is low a pending result is held and in_tready drops,
//   so no request is lost.
// ---------------------------------------------------------------------------
module i2c_master_byte_engine_core #(
  parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [i2cm_pkg::IN_DATA_W-1:0]      in_tdata,
  // [2:0] kind
  input  logic [i2cm_pkg::KIND_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] scl_out, [1] sda_out, [2] sda_released, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_error, [14] cmd_rejected, [15] zero
  output logic [i2cm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [i2cm_pkg::UNIT_W-1:0]         cfg_wdata
);
  import i2cm_pkg::*;

  i2cm_state_t             st_r;
  i2cm_state_t             st_nxt;
  logic [TIMER_WIDTH-1:0]  tmr_r;
  logic [TIMER_WIDTH-1:0]  tmr_nxt;
  logic [UNIT_W-1:0]       unit_ticks_r;
  logic [TOUT_W-1:0]       ack_timeout_r;
  i2cm_result_t            res;
  i2cm_result_t            res_r;
  logic                    out_valid_r;
  logic                    in_acc;

  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(i2cm_result_t)){1'b0}}, res_r};

  i2cm_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .st          (st_r),
    .tmr         (tmr_r),
    .unit_ticks  (unit_ticks_r),
    .ack_timeout (ack_timeout_r),
    .kind        (in_tuser),
    .tx_byte     (in_tdata[7:0]),
    .send_ack    (in_tdata[8]),
    .sda_in      (in_tdata[9]),
    .st_nxt      (st_nxt),
    .tmr_nxt     (tmr_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r  <= UNIT_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_UNIT_TICKS:  unit_ticks_r  <= cfg_wdata;
        CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RST;
      tmr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r        <= st_nxt;
        tmr_r       <= tmr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (res_r.busy_res == (st_r.phase != PH_IDLE)))
    else $error("busy flag disagrees with sequencer phase");

  a_reject_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.cmd_rejected |-> res_r.busy_res && !res_r.done_res)
    else $error("reject reported while idle or finishing");

  a_ack_error_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.ack_error |-> res_r.done_res && !res_r.busy_res)
    else $error("ack error without completed stop");

  a_units_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.units_left != 2'd3)
    else $error("unit count out of range");

  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (st_r.units_left == 2'd0) && (tmr_r == '0))
    else $error("idle engine holds pending wait");
`endif

endmodule

[design/i2cm_step.sv]
// ---------------------------------------------------------------------------
// i2cm_step
// Next-state logic of the line sequencer: applies one request (tick or
// command) to the engine state and forms the result of that request.
// ---------------------------------------------------------------------------
module i2cm_step #(
  parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input  i2cm_pkg::i2cm_state_t            st,
  input  logic [TIMER_WIDTH-1:0]           tmr,
  input  logic [i2cm_pkg::UNIT_W-1:0]      unit_ticks,
  input  logic [i2cm_pkg::TOUT_W-1:0]      ack_timeout,
  input  logic [i2cm_pkg::KIND_W-1:0]      kind,
  input  logic [7:0]                       tx_byte,
  input  logic                             send_ack,
  input  logic                             sda_in,
  output i2cm_pkg::i2cm_state_t            st_nxt,
  output logic [TIMER_WIDTH-1:0]           tmr_nxt,
  output i2cm_pkg::i2cm_result_t           res
);
  import i2cm_pkg::*;

  localparam int CW = ((TIMER_WIDTH > UNIT_W) ? TIMER_WIDTH : UNIT_W) + 1;

  logic [UNIT_W-1:0] eff;
  logic [CW-1:0]     cnt_inc;
  logic              unit_end;
  logic              elapsed;
  logic              done;
  logic              aerr;
  logic              rej;
  logic [3:0]        bit_inc;

  assign eff      = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
  assign cnt_inc  = CW'(tmr) + CW'(1);
  assign unit_end = (cnt_inc >= CW'(eff)) || (tmr == '1);
  assign bit_inc  = st.bit_index + 4'd1;

  always_comb begin
    st_nxt  = st;
    tmr_nxt = tmr;
    done    = 1'b0;
    aerr    = 1'b0;
    rej     = 1'b0;
    elapsed = 1'b0;
    if (kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ}) begin
      if (st.phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tmr_nxt = '0;
        case (kind)
          KIND_START: begin
            st_nxt.sda_rel    = 1'b0;
            st_nxt.sda        = 1'b1;
            st_nxt.scl        = 1'b1;
            st_nxt.phase      = PH_ST_A;
            st_nxt.units_left = 2'd1;
          end
          KIND_STOP: begin
            st_nxt.err_pending = 1'b0;
            st_nxt.sda_rel     = 1'b0;
            st_nxt.scl         = 1'b0;
            st_nxt.sda         = 1'b0;
            st_nxt.phase       = PH_SP_A;
            st_nxt.units_left  = 2'd1;
          end
          KIND_WRITE: begin
            st_nxt.sda_rel    = 1'b0;
            st_nxt.scl        = 1'b0;
            st_nxt.shift_data = tx_byte;
            st_nxt.bit_index  = 4'd0;
            st_nxt.phase      = PH_WR_SET;
            st_nxt.units_left = 2'd1;
          end
          default: begin
            st_nxt.sda_rel    = 1'b1;
            st_nxt.scl        = 1'b0;
            st_nxt.shift_data = 8'd0;
            st_nxt.bit_index  = 4'd0;
            st_nxt.ack_choice = send_ack;
            st_nxt.phase      = PH_RD_LOW;
            st_nxt.units_left = 2'd2;
          end
        endcase
      end
    end else if (kind == KIND_TICK && st.phase != PH_IDLE) begin
      if (st.phase == PH_AK_POLL) begin
        if (!sda_in) begin
          st_nxt.scl        = 1'b0;
          st_nxt.phase      = PH_IDLE;
          st_nxt.units_left = 2'd0;
          tmr_nxt           = '0;
          done              = 1'b1;
        end else if (st.ack_wait >= ack_timeout) begin
          st_nxt.err_pending = 1'b1;
          st_nxt.sda_rel     = 1'b0;
          st_nxt.scl         = 1'b0;
          st_nxt.sda         = 1'b0;
          st_nxt.phase       = PH_SP_A;
          st_nxt.units_left  = 2'd1;
          tmr_nxt            = '0;
        end else begin
          st_nxt.ack_wait = st.ack_wait + TOUT_W'(1);
        end
      end else begin
        if (st.units_left == 2'd0) begin
          elapsed = 1'b1;
        end else if (unit_end) begin
          tmr_nxt           = '0;
          st_nxt.units_left = st.units_left - 2'd1;
          elapsed           = (st.units_left == 2'd1);
        end else begin
          tmr_nxt = tmr + TIMER_WIDTH'(1);
        end
        if (elapsed) begin
          tmr_nxt           = '0;
          st_nxt.units_left = 2'd1;
          case (st.phase)
            PH_ST_A: begin
              st_nxt.sda   = 1'b0;
              st_nxt.phase = PH_ST_B;
            end
            PH_ST_B: begin
              st_nxt.scl        = 1'b0;
              st_nxt.phase      = PH_IDLE;
              st_nxt.units_left = 2'd0;
              done              = 1'b1;
            end
            PH_SP_A: begin
              st_nxt.scl   = 1'b1;
              st_nxt.phase = PH_SP_B;
            end
            PH_SP_B: begin
              st_nxt.sda         = 1'b1;
              st_nxt.phase       = PH_IDLE;
              st_nxt.units_left  = 2'd0;
              done               = 1'b1;
              aerr               = st.err_pending;
              st_nxt.err_pending = 1'b0;
            end
            PH_WR_SET: begin
              st_nxt.sda        = st.shift_data[7];
              st_nxt.shift_data = {st.shift_data[6:0], 1'b0};
              st_nxt.phase      = PH_WR_LOW;
            end
            PH_WR_LOW: begin
              st_nxt.scl   = 1'b1;
              st_nxt.phase = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
              st_nxt.scl       = 1'b0;
              st_nxt.bit_index = bit_inc;
              if (bit_inc < 4'd8) begin
                st_nxt.sda        = st.shift_data[7];
                st_nxt.shift_data = {st.shift_data[6:0], 1'b0};
                st_nxt.phase      = PH_WR_LOW;
              end else begin
                st_nxt.sda_rel = 1'b1;
                st_nxt.phase   = PH_AK_LOW;
              end
            end
            PH_AK_LOW: begin
              st_nxt.scl   = 1'b1;
              st_nxt.phase = PH_AK_DLY;
            end
            PH_AK_DLY: begin
              st_nxt.ack_wait   = '0;
              st_nxt.phase      = PH_AK_POLL;
              st_nxt.units_left = 2'd0;
            end
            PH_RD_LOW: begin
              st_nxt.scl        = 1'b1;
              st_nxt.shift_data = {st.shift_data[6:0], sda_in};
              st_nxt.phase      = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
              st_nxt.bit_index = bit_inc;
              st_nxt.scl       = 1'b0;
              if (bit_inc < 4'd8) begin
                st_nxt.phase      = PH_RD_LOW;
                st_nxt.units_left = 2'd2;
              end else begin
                st_nxt.rx_hold    = st.shift_data;
                st_nxt.sda_rel    = 1'b0;
                st_nxt.sda        = ~st.ack_choice;
                st_nxt.phase      = PH_RA_SET;
                st_nxt.units_left = st.ack_choice ? 2'd1 : 2'd2;
              end
            end
            PH_RA_SET: begin
              st_nxt.scl        = 1'b1;
              st_nxt.phase      = PH_RA_HIGH;
              st_nxt.units_left = 2'd2;
            end
            PH_RA_HIGH: begin
              st_nxt.scl        = 1'b0;
              st_nxt.phase      = PH_IDLE;
              st_nxt.units_left = 2'd0;
              done              = 1'b1;
            end
            default: begin
              st_nxt.phase      = PH_IDLE;
              st_nxt.units_left = 2'd0;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    res.scl_out      = st_nxt.scl;
    res.sda_out      = st_nxt.sda;
    res.sda_released = st_nxt.sda_rel;
    res.busy_res     = (st_nxt.phase != PH_IDLE);
    res.done_res     = done;
    res.rx_byte      = st_nxt.rx_hold;
    res.ack_error    = aerr;
    res.cmd_rejected = rej;
  end

endmodule

[verif/tb_i2c_master_byte_engine_core.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_i2c_master_byte_engine_core
// Self-checking bench for the I2C master byte engine. A line-level tracker
// follows every accepted request (ticks, start, stop, write and read byte)
// and predicts SCL/SDA, busy/done, received byte and error flags. Each
// result is compared in order against the prediction. Stimulus runs
// directed corner sequences, a multi-tick unit sent without gaps, then
// random bus transactions with random ACK behavior, noise and back-pressure.
// ---------------------------------------------------------------------------
module tb_i2c_master_byte_engine_core;
  import i2cm_pkg::*;

  class i2c_line_tracker;
    logic [UNIT_W-1:0]  unit_ticks  = UNIT_TICKS_RST;
    logic [TOUT_W-1:0]  ack_timeout = ACK_TIMEOUT_RST;

    logic [PHASE_W-1:0] phase       = PH_IDLE;
    logic [3:0]         bit_idx     = '0;
    logic [7:0]         shreg       = '0;
    logic [15:0]        utimer      = '0;
    logic [7:0]         ack_cnt     = '0;
    logic               scl         = 1'b0;
    logic               sda         = 1'b0;
    logic               sda_rel     = 1'b0;
    int                 units_left  = 0;
    logic               ack_choice  = 1'b0;
    logic               err_pending = 1'b0;
    logic [7:0]         rx_hold     = '0;

    i2cm_result_t       levels_due[$];
    int                 errors      = 0;

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [UNIT_W-1:0] val);
      if (idx == CFG_UNIT_TICKS) unit_ticks = val;
      else ack_timeout = val[TOUT_W-1:0];
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void enter(logic [PHASE_W-1:0] ph, int units);
      phase      = ph;
      units_left = units;
      utimer     = '0;
    endfunction

    function void finish_seq();
      enter(PH_IDLE, 0);
    endfunction

    function void begin_stop();
      sda_rel = 1'b0;
      scl     = 1'b0;
      sda     = 1'b0;
      enter(PH_SP_A, 1);
    endfunction

    function void put_bit();
      sda   = shreg[7];
      shreg = {shreg[6:0], 1'b0};
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [7:0] tx, logic sack,
                               logic sin);
      i2cm_result_t r;
      bit done, aerr, rej, unit_end;
      logic [16:0] eff, nxt;
      done = 0;
      aerr = 0;
      rej  = 0;
      if (kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ}) begin
        if (phase != PH_IDLE) begin
          rej = 1;
        end else begin
          case (kind)
            KIND_START: begin
              sda_rel = 1'b0;
              sda     = 1'b1;
              scl     = 1'b1;
              enter(PH_ST_A, 1);
            end
            KIND_STOP: begin
              err_pending = 1'b0;
              begin_stop();
            end
            KIND_WRITE: begin
              sda_rel = 1'b0;
              scl     = 1'b0;
              shreg   = tx;
              bit_idx = '0;
              enter(PH_WR_SET, 1);
            end
            default: begin
              sda_rel    = 1'b1;
              scl        = 1'b0;
              shreg      = '0;
              bit_idx    = '0;
              ack_choice = sack;
              enter(PH_RD_LOW, 2);
            end
          endcase
        end
      end else if (kind == KIND_TICK && phase != PH_IDLE) begin
        if (phase == PH_AK_POLL) begin
          if (!sin) begin
            scl = 1'b0;
            finish_seq();
            done = 1;
          end else if (ack_cnt >= ack_timeout) begin
            err_pending = 1'b1;
            begin_stop();
          end else begin
            ack_cnt = ack_cnt + 8'd1;
          end
        end else begin
          eff = (unit_ticks == '0) ? 17'd1 : {1'b0, unit_ticks};
          unit_end = 1;
          if (units_left != 0) begin
            nxt = {1'b0, utimer} + 17'd1;
            if (nxt >= eff || nxt > 17'h0FFFF) begin
              utimer = '0;
              units_left--;
              unit_end = (units_left == 0);
            end else begin
              utimer = nxt[15:0];
              unit_end = 0;
            end
          end
          if (unit_end) begin
            case (phase)
              PH_ST_A: begin
                sda = 1'b0;
                enter(PH_ST_B, 1);
              end
              PH_ST_B: begin
                scl = 1'b0;
                finish_seq();
                done = 1;
              end
              PH_SP_A: begin
                scl = 1'b1;
                enter(PH_SP_B, 1);
              end
              PH_SP_B: begin
                sda = 1'b1;
                finish_seq();
                done = 1;
                aerr = err_pending;
                err_pending = 1'b0;
              end
              PH_WR_SET: begin
                put_bit();
                enter(PH_WR_LOW, 1);
              end
              PH_WR_LOW: begin
                scl = 1'b1;
                enter(PH_WR_HIGH, 1);
              end
              PH_WR_HIGH: begin
                scl = 1'b0;
                bit_idx = bit_idx + 4'd1;
                if (bit_idx < 4'd8) begin
                  put_bit();
                  enter(PH_WR_LOW, 1);
                end else begin
                  sda_rel = 1'b1;
                  enter(PH_AK_LOW, 1);
                end
              end
              PH_AK_LOW: begin
                scl = 1'b1;
                enter(PH_AK_DLY, 1);
              end
              PH_AK_DLY: begin
                ack_cnt = '0;
                enter(PH_AK_POLL, 0);
              end
              PH_RD_LOW: begin
                scl = 1'b1;
                shreg = {shreg[6:0], sin};
                enter(PH_RD_HIGH, 1);
              end
              PH_RD_HIGH: begin
                bit_idx = bit_idx + 4'd1;
                scl = 1'b0;
                if (bit_idx < 4'd8) begin
                  enter(PH_RD_LOW, 2);
                end else begin
                  rx_hold = shreg;
                  sda_rel = 1'b0;
                  sda     = ~ack_choice;
                  enter(PH_RA_SET, ack_choice ? 1 : 2);
                end
              end
              PH_RA_SET: begin
                scl = 1'b1;
                enter(PH_RA_HIGH, 2);
              end
              PH_RA_HIGH: begin
                scl = 1'b0;
                finish_seq();
                done = 1;
              end
              default: finish_seq();
            endcase
          end
        end
      end

      r.scl_out      = scl;
      r.sda_out      = sda;
      r.sda_released = sda_rel;
      r.busy_res     = (phase != PH_IDLE);
      r.done_res     = done;
      r.rx_byte      = rx_hold;
      r.ack_error    = aerr;
      r.cmd_rejected = rej;
      levels_due.push_back(r);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_levels(i2cm_result_t got);
      i2cm_result_t want;
      if (levels_due.size() == 0) begin
        errors++;
        $error("result %h arrived with no request outstanding", got);
        return;
      end
      want = levels_due.pop_front();
      compare("scl_out", want.scl_out, got.scl_out);
      compare("sda_out", want.sda_out, got.sda_out);
      compare("sda_released", want.sda_released, got.sda_released);
      compare("busy_res", want.busy_res, got.busy_res);
      compare("done_res", want.done_res, got.done_res);
      compare("rx_byte", want.rx_byte, got.rx_byte);
      compare("ack_error", want.ack_error, got.ack_error);
      compare("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
    endfunction
  endclass

  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;
  localparam int NEVER_ACK   = 300;
  localparam int QUIET_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  logic [IN_DATA_W-1:0]  in_tdata;
  // [2:0] kind
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] scl_out, [1] sda_out, [2] sda_released, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_error, [14] cmd_rejected, [15] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [UNIT_W-1:0]     cfg_wdata;

  i2c_line_tracker tracker;
  bit              no_gaps = 1'b0;
  int              send_calm = 0;
  int              take_calm = 0;
  int              live_items = 0;
  int unsigned     quiet = 0;

  i2c_master_byte_engine_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int draw_wait(inout int calm);
    if (no_gaps) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 5);
  endfunction

  function automatic int draw_ack_highs();
    return ($urandom_range(0, 3) == 0) ? NEVER_ACK : $urandom_range(0, 3);
  endfunction

  task automatic send_req(logic [KIND_W-1:0] kind, logic [7:0] tx, logic sack,
                          logic sin);
    int n;
    n = draw_wait(send_calm);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, sin, sack, tx};
    do @(posedge clk); while (!in_tready);
    if (tracker.busy() || (kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ}))
      live_items++;
    tracker.note_request(kind, tx, sack, sin);
  endtask

  // hold SDA high for the first ack_highs samples of the ACK poll
  task automatic tick_down(int ack_highs);
    int polled;
    logic s;
    polled = 0;
    while (tracker.busy()) begin
      if (!no_gaps && $urandom_range(0, 15) == 0) begin
        send_req(3'($urandom_range(KIND_START, KIND_BAD_HI)), 8'($urandom),
                 1'($urandom), 1'($urandom));
      end else begin
        if (tracker.phase == PH_AK_POLL) begin
          s = (polled < ack_highs);
          polled++;
        end else begin
          s = 1'($urandom);
        end
        send_req(KIND_TICK, 8'($urandom), 1'($urandom), s);
      end
    end
  endtask

  task automatic run_cmd(logic [KIND_W-1:0] kind, logic [7:0] tx, logic sack,
                         int ack_highs);
    send_req(kind, tx, sack, 1'($urandom));
    tick_down(ack_highs);
  endtask

  task automatic reconfigure(logic [UNIT_W-1:0] ticks, logic [TOUT_W-1:0] tout);
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_UNIT_TICKS;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_addr  <= CFG_ACK_TIMEOUT;
    cfg_wdata <= {8'h00, tout};
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(CFG_UNIT_TICKS, ticks);
    tracker.set_reg(CFG_ACK_TIMEOUT, {8'h00, tout});
  endtask

  task automatic random_phase(int budget);
    int stop_at;
    int pick;
    int cmds;
    stop_at = live_items + budget;
    while (live_items < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_req(($urandom_range(0, 3) == 0) ? KIND_TICK
                   : KIND_BAD_LO + 3'($urandom_range(0, 2)),
                 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 3) begin
        run_cmd(3'($urandom_range(KIND_START, KIND_READ)), 8'($urandom), 1'($urandom),
                draw_ack_highs());
      end else begin
        run_cmd(KIND_START, 8'($urandom), 1'($urandom), 0);
        cmds = $urandom_range(1, 3);
        repeat (cmds)
          run_cmd(($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ, 8'($urandom),
                  1'($urandom), draw_ack_highs());
        run_cmd(KIND_STOP, 8'($urandom), 1'($urandom), 0);
      end
    end
  endtask

  initial begin
    int unused;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      unused = draw_wait(take_calm);
      if (unused > 0) begin
        out_tready <= 1'b0;
        repeat (unused) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else begin
      if (out_tvalid && out_tready)
        tracker.check_levels(i2cm_result_t'(out_tdata[14:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_TICK;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_UNIT_TICKS;
    cfg_wdata = '0;
    tracker   = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle: ticks and unknown kinds change nothing
    send_req(KIND_TICK, 8'hFF, 1'b1, 1'b1);
    send_req(KIND_BAD_LO, 8'h00, 1'b0, 1'b0);
    send_req(KIND_BAD_LO + 3'd1, 8'hFF, 1'b1, 1'b0);
    send_req(KIND_BAD_HI, 8'hFF, 1'b1, 1'b1);

    reconfigure(16'd1, 8'd1);
    // start, busy rejects, unknown kind while busy
    send_req(KIND_START, 8'h00, 1'b0, 1'b0);
    send_req(KIND_READ, 8'hFF, 1'b1, 1'b1);
    send_req(KIND_BAD_HI, 8'h00, 1'b0, 1'b1);
    tick_down(0);
    run_cmd(KIND_WRITE, 8'hFF, 1'b0, NEVER_ACK);
    run_cmd(KIND_WRITE, 8'h00, 1'b1, 0);
    run_cmd(KIND_READ, 8'h00, 1'b1, 0);
    run_cmd(KIND_READ, 8'hFF, 1'b0, 0);
    run_cmd(KIND_STOP, 8'h00, 1'b0, 0);

    reconfigure(16'd0, 8'd4);
    run_cmd(KIND_WRITE, 8'hA5, 1'b0, NEVER_ACK);
    run_cmd(KIND_START, 8'h00, 1'b0, 0);

    reconfigure(16'd12, 8'd2);
    no_gaps = 1'b1;
    run_cmd(KIND_STOP, 8'h00, 1'b0, 0);
    no_gaps = 1'b0;

    reconfigure(16'd1, 8'd3);
    random_phase(60);
    reconfigure(16'd2, 8'd1);
    random_phase(50);
    reconfigure(16'd0, 8'd6);
    random_phase(50);
    reconfigure(16'($urandom_range(1, 4)), 8'($urandom_range(1, 20)));
    random_phase(50);
    reconfigure(16'd3, 8'd10);
    random_phase(50);
    reconfigure(16'd1, 8'($urandom_range(1, 12)));
    random_phase(50);

    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
